@@ src/rmk_pkg.sv @@
// Shared types, widths, constants and the Q.16 gain table for the ranking
// metric block. No dependencies.
package rmk_pkg;

  // Defaults for the top-level parameters
  localparam int DEF_MAX_LABELS = 64;
  localparam int DEF_MAX_K      = 64;
  localparam int DEF_LABEL_BITS = 20;
  localparam int DEF_COUNT_BITS = 8;

  // Fixed port widths
  localparam int REQ_W     = 2;
  localparam int IDX_W     = 20;
  localparam int K_W       = 7;
  localparam int CNT_OUT_W = 8;
  localparam int SML_OUT_W = 7;
  localparam int Q_W       = 20;

  localparam logic [K_W-1:0] RANK_CUTOFF_RST = K_W'(5);

  // Request codes
  localparam logic [REQ_W-1:0] REQ_LABEL = 2'd0;
  localparam logic [REQ_W-1:0] REQ_PRED  = 2'd1;
  localparam logic [REQ_W-1:0] REQ_END   = 2'd2;

  // Gain table: round(65536 / log2(r + 2))
  localparam int GAIN_LEN   = 64;
  localparam int GAIN_IDX_W = 6;
  localparam int GAIN_W     = 17;

  localparam logic [GAIN_W-1:0] GAIN_TBL [GAIN_LEN] = '{
    17'd65536, 17'd41349, 17'd32768, 17'd28225, 17'd25353, 17'd23344, 17'd21845, 17'd20674,
    17'd19728, 17'd18944, 17'd18281, 17'd17710, 17'd17213, 17'd16774, 17'd16384, 17'd16033,
    17'd15716, 17'd15428, 17'd15164, 17'd14921, 17'd14696, 17'd14488, 17'd14294, 17'd14112,
    17'd13943, 17'd13783, 17'd13632, 17'd13490, 17'd13356, 17'd13228, 17'd13107, 17'd12992,
    17'd12882, 17'd12777, 17'd12676, 17'd12580, 17'd12488, 17'd12399, 17'd12314, 17'd12232,
    17'd12154, 17'd12078, 17'd12004, 17'd11933, 17'd11865, 17'd11799, 17'd11734, 17'd11672,
    17'd11612, 17'd11553, 17'd11497, 17'd11441, 17'd11388, 17'd11336, 17'd11285, 17'd11236,
    17'd11187, 17'd11141, 17'd11095, 17'd11050, 17'd11007, 17'd10964, 17'd10923, 17'd10882
  };

  function automatic logic [GAIN_W-1:0] gain_q16(input logic [GAIN_IDX_W-1:0] r);
    return GAIN_TBL[r];
  endfunction

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PRED_SCAN,
    ST_END_SCAN,
    ST_END_OUT
  } rmk_state_t;

  typedef struct packed {
    logic [SML_OUT_W-1:0] hits_at_k;
    logic [CNT_OUT_W-1:0] hits_total;
    logic [CNT_OUT_W-1:0] false_pos;
    logic [SML_OUT_W-1:0] false_neg;
    logic [CNT_OUT_W-1:0] pred_total;
    logic [SML_OUT_W-1:0] label_total;
    logic [Q_W-1:0]       dcg_value;
    logic [Q_W-1:0]       ideal_dcg;
    logic                 overflow;
  } rmk_result_t;

endpackage

@@ src/ranking_metric_at_k.sv @@
// Ranking metric counter for precision, recall and nDCG at k. Send a
// sample as its true labels (req_type 0), then its predictions best first
// (req_type 1), then an end request (req_type 2); the end request yields
// one result with hit counts, false positives and negatives, DCG@k and
// ideal DCG@k in Q4.16, and clears the sample. req_type 3 is taken and
// ignored. Labels live in a single-read, single-write RAM together with a
// matched bit, so a label is stored without a scan, while a prediction or
// an end request walks every stored label, the RAM read port reading one
// label a cycle. The end request also waits for the output register if an
// earlier result is still stalled there. There is no clearing pass after
// reset. rank_cutoff (reset 5) may only be written while idle. Built from
// rmk_pkg, rmk_label_mem, rmk_seq and rmk_out_reg.
module ranking_metric_at_k
  import rmk_pkg::*;
#(
  parameter int MAX_LABELS = DEF_MAX_LABELS,
  parameter int MAX_K      = DEF_MAX_K,
  parameter int LABEL_BITS = DEF_LABEL_BITS,
  parameter int COUNT_BITS = DEF_COUNT_BITS
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_wr_en,
  input  logic [K_W-1:0]       cfg_wr_data,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [REQ_W-1:0]     req_type,
  input  logic [IDX_W-1:0]     label_index,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [SML_OUT_W-1:0] hits_at_k,
  output logic [CNT_OUT_W-1:0] hits_total,
  output logic [CNT_OUT_W-1:0] false_pos,
  output logic [SML_OUT_W-1:0] false_neg,
  output logic [CNT_OUT_W-1:0] pred_total,
  output logic [SML_OUT_W-1:0] label_total,
  output logic [Q_W-1:0]       dcg_value,
  output logic [Q_W-1:0]       ideal_dcg,
  output logic                 overflow
);

  localparam int ADDR_W = (MAX_LABELS > 1) ? $clog2(MAX_LABELS) : 1;

  logic [K_W-1:0]      rank_cutoff;
  logic                mem_wr_en;
  logic [ADDR_W-1:0]   mem_wr_addr;
  logic [LABEL_BITS:0] mem_wr_data;
  logic                mem_rd_en;
  logic [ADDR_W-1:0]   mem_rd_addr;
  logic [LABEL_BITS:0] mem_rd_data;
  logic                slot_free;
  logic                res_load;
  rmk_result_t         res;
  rmk_result_t         res_q;

  // k register: the user must write it only between samples; not enforced here
  always_ff @(posedge clk) begin
    if (rst) begin
      rank_cutoff <= RANK_CUTOFF_RST;
    end else if (cfg_wr_en) begin
      rank_cutoff <= cfg_wr_data;
    end
  end

  // Label store, one {matched, label} word per entry
  rmk_label_mem #(
    .DEPTH  (MAX_LABELS),
    .ADDR_W (ADDR_W),
    .DATA_W (LABEL_BITS + 1)
  ) u_mem (
    .clk     (clk),
    .wr_en   (mem_wr_en),
    .wr_addr (mem_wr_addr),
    .wr_data (mem_wr_data),
    .rd_en   (mem_rd_en),
    .rd_addr (mem_rd_addr),
    .rd_data (mem_rd_data)
  );

  // Request sequencer and per-sample counters
  rmk_seq #(
    .MAX_LABELS (MAX_LABELS),
    .MAX_K      (MAX_K),
    .LABEL_BITS (LABEL_BITS),
    .COUNT_BITS (COUNT_BITS),
    .ADDR_W     (ADDR_W)
  ) u_seq (
    .clk         (clk),
    .rst         (rst),
    .rank_cutoff (rank_cutoff),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .req_type    (req_type),
    .label_index (label_index),
    .mem_wr_en   (mem_wr_en),
    .mem_wr_addr (mem_wr_addr),
    .mem_wr_data (mem_wr_data),
    .mem_rd_en   (mem_rd_en),
    .mem_rd_addr (mem_rd_addr),
    .mem_rd_data (mem_rd_data),
    .slot_free   (slot_free),
    .res_load    (res_load),
    .res         (res)
  );

  // Result register; the next sample starts while a result waits here
  rmk_out_reg u_out (
    .clk       (clk),
    .rst       (rst),
    .load      (res_load),
    .res_in    (res),
    .slot_free (slot_free),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .res_out   (res_q)
  );

  assign hits_at_k   = res_q.hits_at_k;
  assign hits_total  = res_q.hits_total;
  assign false_pos   = res_q.false_pos;
  assign false_neg   = res_q.false_neg;
  assign pred_total  = res_q.pred_total;
  assign label_total = res_q.label_total;
  assign dcg_value   = res_q.dcg_value;
  assign ideal_dcg   = res_q.ideal_dcg;
  assign overflow    = res_q.overflow;

endmodule

@@ src/rmk_label_mem.sv @@
// Label store: single-port-write, single-port-read synchronous RAM holding
// {matched, label} words. Depends on nothing.
module rmk_label_mem #(
  parameter int DEPTH  = 64,
  parameter int ADDR_W = 6,
  parameter int DATA_W = 21
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [DATA_W-1:0] wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [DATA_W-1:0] rd_data
);

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

@@ src/rmk_seq.sv @@
// Sequencer: takes requests, walks the label store one entry a cycle and
// keeps the per-sample counters. Depends on rmk_pkg.
module rmk_seq
  import rmk_pkg::*;
#(
  parameter int MAX_LABELS = DEF_MAX_LABELS,
  parameter int MAX_K      = DEF_MAX_K,
  parameter int LABEL_BITS = DEF_LABEL_BITS,
  parameter int COUNT_BITS = DEF_COUNT_BITS,
  parameter int ADDR_W     = 6
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic [K_W-1:0]        rank_cutoff,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [REQ_W-1:0]      req_type,
  input  logic [IDX_W-1:0]      label_index,
  output logic                  mem_wr_en,
  output logic [ADDR_W-1:0]     mem_wr_addr,
  output logic [LABEL_BITS:0]   mem_wr_data,
  output logic                  mem_rd_en,
  output logic [ADDR_W-1:0]     mem_rd_addr,
  input  logic [LABEL_BITS:0]   mem_rd_data,
  input  logic                  slot_free,
  output logic                  res_load,
  output rmk_result_t           res
);

  localparam int FILL_W = $clog2(MAX_LABELS + 1);
  localparam int K_LIM  = (MAX_K < GAIN_LEN) ? MAX_K : GAIN_LEN;
  localparam int CMP_A  = (COUNT_BITS > K_W) ? COUNT_BITS : K_W;
  localparam int CMP_W  = (CMP_A > ADDR_W) ? CMP_A : ADDR_W;

  rmk_state_t state, state_next;

  logic [FILL_W-1:0]     fill, fill_next;
  logic [COUNT_BITS-1:0] pred_rank, pred_rank_next;
  logic [K_W-1:0]        hit_k, hit_k_next;
  logic [COUNT_BITS-1:0] hit_all, hit_all_next;
  logic [COUNT_BITS-1:0] miss, miss_next;
  logic [Q_W-1:0]        dcg_sum, dcg_sum_next;
  logic                  sat_flag, sat_next;
  logic [FILL_W-1:0]     fn_count, fn_next;
  logic [Q_W-1:0]        ideal_acc, ideal_next;

  logic [FILL_W-1:0]     rd_idx;
  logic                  rd_pend;
  logic [ADDR_W-1:0]     rd_addr_q;
  logic [LABEL_BITS-1:0] pred_label;
  logic                  hit_acc;

  logic                  in_accept;
  logic                  scanning;
  logic                  rd_issue;
  logic                  scan_done;
  logic                  rd_match;
  logic                  store_full;
  logic [K_W-1:0]        k_eff;
  logic [Q_W:0]          dcg_sum_w;
  logic [Q_W:0]          ideal_sum_w;

  assign in_stall   = (state != ST_IDLE);
  assign in_accept  = in_valid && !in_stall;
  assign k_eff      = (rank_cutoff > K_W'(K_LIM)) ? K_W'(K_LIM) : rank_cutoff;
  assign store_full = (fill >= FILL_W'(MAX_LABELS));

  assign scanning  = (state == ST_PRED_SCAN) || (state == ST_END_SCAN);
  assign rd_issue  = scanning && (rd_idx != fill);
  assign scan_done = (rd_idx == fill) && !rd_pend;
  assign rd_match  = (state == ST_PRED_SCAN) && rd_pend &&
                     (mem_rd_data[LABEL_BITS-1:0] == pred_label);

  assign mem_rd_en   = rd_issue;
  assign mem_rd_addr = rd_idx[ADDR_W-1:0];

  // Write port: new labels while idle, matched-bit write-back during a scan
  always_comb begin
    mem_wr_en   = 1'b0;
    mem_wr_addr = fill[ADDR_W-1:0];
    mem_wr_data = {1'b0, LABEL_BITS'(label_index)};
    if (in_accept && (req_type == REQ_LABEL) && !store_full) begin
      mem_wr_en = 1'b1;
    end else if (rd_match) begin
      mem_wr_en   = 1'b1;
      mem_wr_addr = rd_addr_q;
      mem_wr_data = {1'b1, mem_rd_data[LABEL_BITS-1:0]};
    end
  end

  assign dcg_sum_w   = {1'b0, dcg_sum} + (Q_W+1)'(gain_q16(GAIN_IDX_W'(pred_rank)));
  assign ideal_sum_w = {1'b0, ideal_acc} + (Q_W+1)'(gain_q16(GAIN_IDX_W'(rd_addr_q)));

  always_comb begin
    state_next     = state;
    fill_next      = fill;
    pred_rank_next = pred_rank;
    hit_k_next     = hit_k;
    hit_all_next   = hit_all;
    miss_next      = miss;
    dcg_sum_next   = dcg_sum;
    sat_next       = sat_flag;
    fn_next        = fn_count;
    ideal_next     = ideal_acc;
    res_load       = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (in_accept) begin
          priority if (req_type == REQ_LABEL) begin
            if (store_full) begin
              sat_next = 1'b1;
            end else begin
              fill_next = fill + FILL_W'(1);
            end
          end else if (req_type == REQ_PRED) begin
            state_next = ST_PRED_SCAN;
          end else if (req_type == REQ_END) begin
            fn_next    = '0;
            ideal_next = '0;
            state_next = ST_END_SCAN;
          end else begin
            state_next = ST_IDLE;
          end
        end
      end
      ST_PRED_SCAN: begin
        if (scan_done) begin
          if (hit_acc) begin
            if (hit_all == '1) begin
              sat_next = 1'b1;
            end else begin
              hit_all_next = hit_all + COUNT_BITS'(1);
            end
            if (CMP_W'(pred_rank) < CMP_W'(k_eff)) begin
              hit_k_next = hit_k + K_W'(1);
              if (dcg_sum_w[Q_W]) begin
                dcg_sum_next = '1;
                sat_next     = 1'b1;
              end else begin
                dcg_sum_next = dcg_sum_w[Q_W-1:0];
              end
            end
          end else begin
            if (miss == '1) begin
              sat_next = 1'b1;
            end else begin
              miss_next = miss + COUNT_BITS'(1);
            end
          end
          if (pred_rank == '1) begin
            sat_next = 1'b1;
          end else begin
            pred_rank_next = pred_rank + COUNT_BITS'(1);
          end
          state_next = ST_IDLE;
        end
      end
      ST_END_SCAN: begin
        if (rd_pend) begin
          if (!mem_rd_data[LABEL_BITS]) begin
            fn_next = fn_count + FILL_W'(1);
          end
          if (CMP_W'(rd_addr_q) < CMP_W'(k_eff)) begin
            if (ideal_sum_w[Q_W]) begin
              ideal_next = '1;
              sat_next   = 1'b1;
            end else begin
              ideal_next = ideal_sum_w[Q_W-1:0];
            end
          end
        end
        if (scan_done) begin
          state_next = ST_END_OUT;
        end
      end
      ST_END_OUT: begin
        if (slot_free) begin
          res_load       = 1'b1;
          fill_next      = '0;
          pred_rank_next = '0;
          hit_k_next     = '0;
          hit_all_next   = '0;
          miss_next      = '0;
          dcg_sum_next   = '0;
          sat_next       = 1'b0;
          state_next     = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    res.hits_at_k   = hit_k;
    res.hits_total  = CNT_OUT_W'(hit_all);
    res.false_pos   = CNT_OUT_W'(miss);
    res.false_neg   = SML_OUT_W'(fn_count);
    res.pred_total  = CNT_OUT_W'(pred_rank);
    res.label_total = SML_OUT_W'(fill);
    res.dcg_value   = dcg_sum;
    res.ideal_dcg   = ideal_acc;
    res.overflow    = sat_flag;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      fill      <= '0;
      pred_rank <= '0;
      hit_k     <= '0;
      hit_all   <= '0;
      miss      <= '0;
      dcg_sum   <= '0;
      sat_flag  <= 1'b0;
      fn_count  <= '0;
      ideal_acc <= '0;
      rd_idx    <= '0;
      rd_pend   <= 1'b0;
      hit_acc   <= 1'b0;
    end else begin
      state     <= state_next;
      fill      <= fill_next;
      pred_rank <= pred_rank_next;
      hit_k     <= hit_k_next;
      hit_all   <= hit_all_next;
      miss      <= miss_next;
      dcg_sum   <= dcg_sum_next;
      sat_flag  <= sat_next;
      fn_count  <= fn_next;
      ideal_acc <= ideal_next;
      rd_pend   <= rd_issue;
      if (in_accept) begin
        rd_idx <= '0;
      end else if (rd_issue) begin
        rd_idx <= rd_idx + FILL_W'(1);
      end
      if (in_accept) begin
        hit_acc <= 1'b0;
      end else if (rd_match) begin
        hit_acc <= 1'b1;
      end
    end
  end

  // Hold the entry address alongside its read and latch the prediction label
  always_ff @(posedge clk) begin
    if (rd_issue) begin
      rd_addr_q <= rd_idx[ADDR_W-1:0];
    end
    if (in_accept) begin
      pred_label <= LABEL_BITS'(label_index);
    end
  end

endmodule

@@ src/rmk_out_reg.sv @@
// Output register for one result request with valid/stall handshake.
// Depends on rmk_pkg.
module rmk_out_reg
  import rmk_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        load,
  input  rmk_result_t res_in,
  output logic        slot_free,
  output logic        out_valid,
  input  logic        out_stall,
  output rmk_result_t res_out
);

  assign slot_free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_out <= res_in;
    end
  end

endmodule

@@ src/rmk_checker.sv @@
// Port-level checks for ranking_metric_at_k, bound to the top level.
// Depends on rmk_pkg.
module rmk_checker
  import rmk_pkg::*;
(
  input logic                 clk,
  input logic                 rst,
  input logic                 out_valid,
  input logic                 out_stall,
  input logic [SML_OUT_W-1:0] hits_at_k,
  input logic [CNT_OUT_W-1:0] hits_total,
  input logic [CNT_OUT_W-1:0] false_pos,
  input logic [SML_OUT_W-1:0] false_neg,
  input logic [CNT_OUT_W-1:0] pred_total,
  input logic [SML_OUT_W-1:0] label_total,
  input logic [Q_W-1:0]       dcg_value,
  input logic [Q_W-1:0]       ideal_dcg,
  input logic                 overflow
);

  // Every prediction is either a hit or a miss
  a_pred_split: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((({1'b0, hits_total} + {1'b0, false_pos}) == {1'b0, pred_total})
                   || overflow))
    else $error("hits plus false positives differ from predictions");

  // Hits in the top k are a subset of all hits
  a_hitk_le_all: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((CNT_OUT_W'(hits_at_k) <= hits_total) || overflow))
    else $error("hits at k exceed total hits");

  // Unmatched labels cannot outnumber stored labels
  a_fn_le_labels: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (false_neg <= label_total))
    else $error("false negatives exceed label count");

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(dcg_value) && $stable(ideal_dcg)
                                  && $stable(hits_total)))
    else $error("stalled result changed");

endmodule

bind ranking_metric_at_k rmk_checker u_rmk_checker (.*);

@@ sim/testbench.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for ranking_metric_at_k: random and directed samples
// scored against an in-bench predictor. Depends on rmk_pkg and the block only.
module testbench;
  import rmk_pkg::*;

  // Code 3 on req_type is taken by the block and ignored
  localparam logic [REQ_W-1:0] REQ_NONE = 2'd3;

  localparam int LIMIT_CYCLES = 1000000;
  localparam int HOLD_CYCLES  = 1500;
  localparam int RANDOM_ITEMS = 1000;
  localparam int PHASES       = 6;
  localparam int STORE_DEPTH  = 64;

  // Predictor of the per-sample counts plus the queue of results still owed
  class metric_scoreboard;
    logic [IDX_W-1:0] label_mem [STORE_DEPTH];
    bit               matched [STORE_DEPTH];
    logic [6:0]       label_count;
    logic [7:0]       rank_pos;
    logic [7:0]       hit_all;
    logic [7:0]       misses;
    logic [6:0]       hit_k;
    logic [20:0]      dcg_acc;
    bit               sat;
    logic [K_W-1:0]   cutoff;
    int unsigned      gain_q16 [64];
    rmk_result_t      expected_q [$];
    int               errors;
    int               results;

    function new();
      gain_q16 = '{
        65536, 41349, 32768, 28225, 25353, 23344, 21845, 20674,
        19728, 18944, 18281, 17710, 17213, 16774, 16384, 16033,
        15716, 15428, 15164, 14921, 14696, 14488, 14294, 14112,
        13943, 13783, 13632, 13490, 13356, 13228, 13107, 12992,
        12882, 12777, 12676, 12580, 12488, 12399, 12314, 12232,
        12154, 12078, 12004, 11933, 11865, 11799, 11734, 11672,
        11612, 11553, 11497, 11441, 11388, 11336, 11285, 11236,
        11187, 11141, 11095, 11050, 11007, 10964, 10923, 10882
      };
      cutoff  = RANK_CUTOFF_RST;
      errors  = 0;
      results = 0;
      clear_sample();
    endfunction

    function void clear_sample();
      for (int i = 0; i < STORE_DEPTH; i++) matched[i] = 1'b0;
      label_count = '0;
      rank_pos    = '0;
      hit_all     = '0;
      misses      = '0;
      hit_k       = '0;
      dcg_acc     = '0;
      sat         = 1'b0;
    endfunction

    // Saturating step for the 8-bit counters
    function logic [7:0] bump(logic [7:0] v);
      if (v == 8'hFF) begin
        sat = 1'b1;
        return v;
      end
      return v + 8'd1;
    endfunction

    function void set_cutoff(logic [K_W-1:0] v);
      cutoff = v;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function void note_request(logic [REQ_W-1:0] req, logic [IDX_W-1:0] idx);
      bit          hit;
      logic [6:0]  k;
      logic [6:0]  lim;
      logic [6:0]  fn;
      logic [20:0] ideal;
      rmk_result_t r;
      k = (cutoff > 7'd64) ? 7'd64 : cutoff;
      case (req)
        REQ_LABEL: begin
          if (label_count < 7'd64) begin
            label_mem[label_count] = idx;
            matched[label_count]   = 1'b0;
            label_count++;
          end else begin
            sat = 1'b1;
          end
        end
        REQ_PRED: begin
          hit = 1'b0;
          for (int i = 0; i < label_count; i++) begin
            if (label_mem[i] == idx) begin
              hit        = 1'b1;
              matched[i] = 1'b1;
            end
          end
          if (hit) begin
            hit_all = bump(hit_all);
            if (rank_pos < k) begin
              hit_k++;
              dcg_acc = dcg_acc + gain_q16[rank_pos];
              if (dcg_acc > 21'hFFFFF) begin
                sat     = 1'b1;
                dcg_acc = 21'hFFFFF;
              end
            end
          end else begin
            misses = bump(misses);
          end
          rank_pos = bump(rank_pos);
        end
        REQ_END: begin
          fn = '0;
          for (int i = 0; i < label_count; i++) if (!matched[i]) fn++;
          lim   = (label_count < k) ? label_count : k;
          ideal = '0;
          for (int i = 0; i < lim; i++) begin
            ideal = ideal + gain_q16[i];
            if (ideal > 21'hFFFFF) begin
              sat   = 1'b1;
              ideal = 21'hFFFFF;
            end
          end
          r.hits_at_k   = hit_k;
          r.hits_total  = hit_all;
          r.false_pos   = misses;
          r.false_neg   = fn;
          r.pred_total  = rank_pos;
          r.label_total = label_count;
          r.dcg_value   = dcg_acc[19:0];
          r.ideal_dcg   = ideal[19:0];
          r.overflow    = sat;
          expected_q = {expected_q, r};
          clear_sample();
        end
        default: ;
      endcase
    endfunction

    task report(string msg);
      errors++;
      if (errors <= 60) $display("[%0t] mismatch: %s", $time, msg);
    endtask

    task compare_field(string name, int unsigned got, int unsigned want);
      if (got != want) report($sformatf("%s got %0d, expected %0d", name, got, want));
    endtask

    task check_result(rmk_result_t got);
      rmk_result_t want;
      if (expected_q.size() == 0) begin
        report("result arrived with no sample closed");
        return;
      end
      want = expected_q.pop_front();
      results++;
      compare_field("hits_at_k", got.hits_at_k, want.hits_at_k);
      compare_field("hits_total", got.hits_total, want.hits_total);
      compare_field("false_pos", got.false_pos, want.false_pos);
      compare_field("false_neg", got.false_neg, want.false_neg);
      compare_field("pred_total", got.pred_total, want.pred_total);
      compare_field("label_total", got.label_total, want.label_total);
      compare_field("dcg_value", got.dcg_value, want.dcg_value);
      compare_field("ideal_dcg", got.ideal_dcg, want.ideal_dcg);
      compare_field("overflow", got.overflow, want.overflow);
    endtask
  endclass

  logic                 clk         = 1'b0;
  logic                 rst         = 1'b1;
  logic                 cfg_wr_en   = 1'b0;
  logic [K_W-1:0]       cfg_wr_data = '0;
  logic                 in_valid    = 1'b0;
  logic                 in_stall;
  logic [REQ_W-1:0]     req_type    = REQ_LABEL;
  logic [IDX_W-1:0]     label_index = '0;
  logic                 out_valid;
  logic                 out_stall   = 1'b0;
  logic [SML_OUT_W-1:0] hits_at_k;
  logic [CNT_OUT_W-1:0] hits_total;
  logic [CNT_OUT_W-1:0] false_pos;
  logic [SML_OUT_W-1:0] false_neg;
  logic [CNT_OUT_W-1:0] pred_total;
  logic [SML_OUT_W-1:0] label_total;
  logic [Q_W-1:0]       dcg_value;
  logic [Q_W-1:0]       ideal_dcg;
  logic                 overflow;

  metric_scoreboard sb;
  rmk_result_t      got_result;
  int               cycle_count   = 0;
  int               items_sent    = 0;
  int               cutoff_writes = 0;
  bit               calm          = 1'b0;   // no gaps on the request side
  int               hold_req      = 0;      // bumped to ask for a long hold-off
  int               hold_seen     = 0;
  int               hold_left     = 0;
  int               run_left      = 0;
  int               pick;

  ranking_metric_at_k DUT (
    .clk        (clk),
    .rst        (rst),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .req_type   (req_type),
    .label_index(label_index),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .hits_at_k  (hits_at_k),
    .hits_total (hits_total),
    .false_pos  (false_pos),
    .false_neg  (false_neg),
    .pred_total (pred_total),
    .label_total(label_total),
    .dcg_value  (dcg_value),
    .ideal_dcg  (ideal_dcg),
    .overflow   (overflow)
  );

  always #1 clk = ~clk;

  // Watchdog: abandon the run if it never drains
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("timeout after %0d cycles, %0d results owed", cycle_count, sb.pending());
      $display("FAIL");
      $finish;
    end
  end

  // Result side: check each accepted result, then choose the stall for the
  // next cycle. A long hold-off, once asked for, overrides the random pattern.
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      got_result.hits_at_k   = hits_at_k;
      got_result.hits_total  = hits_total;
      got_result.false_pos   = false_pos;
      got_result.false_neg   = false_neg;
      got_result.pred_total  = pred_total;
      got_result.label_total = label_total;
      got_result.dcg_value   = dcg_value;
      got_result.ideal_dcg   = ideal_dcg;
      got_result.overflow    = overflow;
      sb.check_result(got_result);
    end
    if (hold_req != hold_seen) begin
      hold_seen <= hold_req;
      hold_left <= HOLD_CYCLES;
      out_stall <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else if (run_left > 0) begin
      run_left <= run_left - 1;
    end else begin
      pick = $urandom_range(0, 99);
      if (pick < 45) begin
        out_stall <= 1'b0;
        run_left  <= $urandom_range(0, 15);
      end else if (pick < 80) begin
        out_stall <= 1'b1;
        run_left  <= $urandom_range(0, 2);
      end else if (pick < 92) begin
        out_stall <= 1'b0;
        run_left  <= $urandom_range(30, 120);
      end else begin
        out_stall <= 1'b1;
        run_left  <= $urandom_range(8, 40);
      end
    end
  end

  // Mostly back-to-back, sometimes a short gap, now and then a long gap
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [IDX_W-1:0] fresh_label(bit pool);
    // A small pool forces collisions between labels and predictions
    if (pool) return IDX_W'($urandom_range(0, 15));
    return IDX_W'($urandom);
  endfunction

  // Offer one request and hold it until the block takes it. Valid is left
  // high on return so that a following request can go out back-to-back.
  task automatic send(logic [REQ_W-1:0] req, logic [IDX_W-1:0] idx);
    int gap;
    gap = calm ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid    <= 1'b1;
    req_type    <= req;
    label_index <= idx;
    do @(posedge clk); while (in_stall);
    sb.note_request(req, idx);
    if (req != REQ_NONE) items_sent++;
  endtask

  // Drop valid, wait for every owed result, then let the block settle
  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (80) @(posedge clk);
  endtask

  // Only called with the block idle
  task automatic write_cutoff(logic [K_W-1:0] v);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    sb.set_cutoff(v);
    cutoff_writes++;
  endtask

  // One well-formed sample with random content; late labels and ignored
  // requests are sprinkled among the predictions
  task automatic run_sample(int n_lab, int n_pred, bit pool, int hit_pct);
    logic [IDX_W-1:0] vals [$];
    logic [IDX_W-1:0] v;
    for (int i = 0; i < n_lab; i++) begin
      v = fresh_label(pool);
      vals = {vals, v};
      send(REQ_LABEL, v);
    end
    for (int i = 0; i < n_pred; i++) begin
      if ($urandom_range(0, 15) == 0) begin
        v = fresh_label(pool);
        vals = {vals, v};
        send(REQ_LABEL, v);
      end
      if ($urandom_range(0, 19) == 0) send(REQ_NONE, IDX_W'($urandom));
      if (vals.size() > 0 && $urandom_range(0, 99) < hit_pct)
        v = vals[$urandom_range(0, vals.size() - 1)];
      else
        v = fresh_label(pool);
      send(REQ_PRED, v);
    end
    send(REQ_END, IDX_W'($urandom));
  endtask

  task automatic random_sample();
    int r;
    int n_lab;
    int n_pred;
    calm = ($urandom_range(0, 3) == 0);
    r = $urandom_range(0, 99);
    if (r < 10)      n_lab = 0;
    else if (r < 80) n_lab = $urandom_range(1, 8);
    else if (r < 95) n_lab = $urandom_range(9, 24);
    else             n_lab = $urandom_range(50, 70);
    r = $urandom_range(0, 99);
    if (r < 10)      n_pred = 0;
    else if (r < 75) n_pred = $urandom_range(1, 10);
    else if (r < 92) n_pred = $urandom_range(11, 30);
    else             n_pred = $urandom_range(60, 72);
    run_sample(n_lab, n_pred, $urandom_range(0, 1), $urandom_range(20, 80));
  endtask

  initial begin
    logic [K_W-1:0] ks [PHASES];
    int             rand_base;
    sb = new();

    // Hold reset, then release it for good
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed samples at the reset cutoff of five. The first one has
    // duplicate labels, a duplicate prediction, a miss, a label arriving
    // after predictions, a hit past the cutoff and an ignored request.
    send(REQ_LABEL, '0);
    send(REQ_LABEL, '1);
    send(REQ_LABEL, 20'h12345);
    send(REQ_LABEL, 20'h12345);
    send(REQ_PRED, '1);
    send(REQ_PRED, 20'h55555);
    send(REQ_PRED, 20'h12345);
    send(REQ_PRED, 20'h12345);
    send(REQ_LABEL, 20'h00ABC);
    send(REQ_PRED, 20'h00ABC);
    send(REQ_PRED, '0);
    send(REQ_NONE, 20'hAAAAA);
    send(REQ_END, '0);
    // Empty sample, labels only, predictions only
    send(REQ_END, '1);
    send(REQ_LABEL, 20'h00007);
    send(REQ_END, '0);
    send(REQ_PRED, 20'h00003);
    send(REQ_END, '0);
    drain();

    // Random phases, each under its own cutoff: one, the largest, zero,
    // above the clamp, then two random ones
    ks[0] = 7'd1;
    ks[1] = 7'd64;
    ks[2] = 7'd0;
    ks[3] = 7'd127;
    ks[4] = K_W'($urandom_range(2, 63));
    ks[5] = K_W'($urandom_range(65, 126));
    rand_base = items_sent;
    for (int p = 0; p < PHASES; p++) begin
      write_cutoff(ks[p]);
      if (p == 1) begin
        // Overfill the label store with random labels; each prediction names a sent label
        calm = 1'b0;
        run_sample($urandom_range(65, 70), $urandom_range(60, 70), 1'b0, 100);
        // Saturate the hit counter and the rank counter
        run_sample($urandom_range(1, 2), $urandom_range(258, 262), 1'b0, 100);
        // Saturate the miss counter with no labels at all
        run_sample(0, $urandom_range(260, 266), 1'b0, 0);
      end
      if (p == 3) begin
        // Stall the result side for a long stretch while short samples keep
        // arriving, so the output register fills and requests back up
        hold_req <= hold_req + 1;
        calm = 1'b1;
        repeat (12) run_sample($urandom_range(1, 3), $urandom_range(1, 3), 1'b1, 50);
      end
      while (items_sent - rand_base < (p + 1) * RANDOM_ITEMS / PHASES) random_sample();
      drain();
    end

    repeat (100) @(posedge clk);
    $display("Sent %0d requests under %0d cutoff values; %0d results checked.",
             items_sent, cutoff_writes + 1, sb.results);
    $display("Mismatches counted: %0d", sb.errors);
    if (sb.errors == 0 && sb.pending() == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule
